// ----- design/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator
// Transfer structs, status and operation codes, and the control and status
// groups passed between the sequencer and the tail stage of the cell ring.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Operation codes carried in the kind field.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOFIT    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  // One request transfer.
  typedef struct packed {
    logic        kind;
    logic [7:0]  owner_id;
    logic [10:0] request_size;
  } req_t;

  // One result transfer.
  typedef struct packed {
    logic       ok;
    logic [2:0] status;
  } rsp_t;

  // What the tail stage does to the entries streaming past it.
  typedef enum logic [1:0] {
    TM_PASS,
    TM_ALLOC,
    TM_FREE
  } tail_mode_e;

  typedef struct packed {
    tail_mode_e mode;
    logic       flush;
  } tail_ctrl_t;

  // Observations of the tail stage on the head entry and its own state.
  typedef struct packed {
    logic match;
    logic fit;
    logic exact;
    logic pend_v;
    logic split;
    logic merge;
  } tail_stat_t;

endpackage

`default_nettype wire

// ----- design/first_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit heap segment allocator
// Keeps the ordered segment table in a ring of cells that rotates every cycle
// and answers allocate and free commands with one status result each.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on rsp_o for exactly one cycle with done_o high and must be taken then.
// An allocate of size zero is answered in the cycle after it is taken. Any
// other command waits for the head of the list to reach the ring's head
// slot, then scans one full revolution of the ring. A command that changes
// the table rotates once more and then drains the pending register into a
// free slot. The ring rotates by one slot per cycle.
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int HEAP_WORDS    = 1024,
  parameter int OWNER_BITS    = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ffba_pkg::req_t req_i,
  output logic                done_o,
  output ffba_pkg::rsp_t      rsp_o
);

  localparam int LEN_W = $clog2(HEAP_WORDS + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SYNC  = 3'd1;
  localparam logic [2:0] S_LAP1  = 3'd2;
  localparam logic [2:0] S_LAP2  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // Ring signals: slot i takes slot i+1, the last slot takes the tail output.
  logic                  cv    [TABLE_ENTRIES];
  logic                  cf    [TABLE_ENTRIES];
  logic                  cfr   [TABLE_ENTRIES];
  logic [OWNER_BITS-1:0] cown  [TABLE_ENTRIES];
  logic [LEN_W-1:0]      clen  [TABLE_ENTRIES];
  logic                  nv    [TABLE_ENTRIES];
  logic                  nf    [TABLE_ENTRIES];
  logic                  nfr   [TABLE_ENTRIES];
  logic [OWNER_BITS-1:0] nown  [TABLE_ENTRIES];
  logic [LEN_W-1:0]      nlen  [TABLE_ENTRIES];

  logic                  tv, tf, tfr;
  logic [OWNER_BITS-1:0] town;
  logic [LEN_W-1:0]      tlen;

  ffba_pkg::tail_ctrl_t  ctrl;
  ffba_pkg::tail_stat_t  stat;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  kind_q;
  logic [OWNER_BITS-1:0] who_q;
  logic [10:0]           size_q;
  logic                  own_q, own_d, fit_q, fit_d, exact_q, exact_d;
  logic                  done_q, done_d;
  ffba_pkg::rsp_t        rsp_q, rsp_d;
  logic                  latch;
  logic [15:0]           who_wide;
  logic                  head_first, lap_last, full;
  logic                  own_n, fit_n, exact_n;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ring
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign nv[i]   = tv;
      assign nf[i]   = tf;
      assign nfr[i]  = tfr;
      assign nown[i] = town;
      assign nlen[i] = tlen;
    end else begin : g_mid
      assign nv[i]   = cv[i+1];
      assign nf[i]   = cf[i+1];
      assign nfr[i]  = cfr[i+1];
      assign nown[i] = cown[i+1];
      assign nlen[i] = clen[i+1];
    end

    ffba_cell #(
      .LEN_W      (LEN_W),
      .OWN_W      (OWNER_BITS),
      .HEAP_WORDS (HEAP_WORDS),
      .HEAD       (i == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (nv[i]),
      .f_i    (nf[i]),
      .fr_i   (nfr[i]),
      .own_i  (nown[i]),
      .len_i  (nlen[i]),
      .v_o    (cv[i]),
      .f_o    (cf[i]),
      .fr_o   (cfr[i]),
      .own_o  (cown[i]),
      .len_o  (clen[i])
    );
  end

  ffba_tail #(
    .LEN_W (LEN_W),
    .OWN_W (OWNER_BITS)
  ) u_tail (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .who_i     (who_q),
    .size_i    (size_q),
    .in_v_i    (cv[0]),
    .in_f_i    (cf[0]),
    .in_fr_i   (cfr[0]),
    .in_own_i  (cown[0]),
    .in_len_i  (clen[0]),
    .out_v_o   (tv),
    .out_f_o   (tf),
    .out_fr_o  (tfr),
    .out_own_o (town),
    .out_len_o (tlen),
    .stat_o    (stat)
  );

  // Tail mode follows the phase of the command.
  always_comb begin
    ctrl.flush = (state_q == S_FLUSH);
    if ((state_q == S_LAP2) || (state_q == S_FLUSH)) begin
      ctrl.mode = (kind_q == ffba_pkg::KIND_FREE) ? ffba_pkg::TM_FREE : ffba_pkg::TM_ALLOC;
    end else begin
      ctrl.mode = ffba_pkg::TM_PASS;
    end
  end

  // Scan flags including the head entry seen in this cycle.
  always_comb begin
    head_first = cv[0] && cf[0];
    lap_last   = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));
    full       = (count_q == CNT_W'(TABLE_ENTRIES));
    own_n      = own_q | stat.match;
    fit_n      = fit_q | stat.fit;
    exact_n    = (stat.fit && !fit_q) ? stat.exact : exact_q;
    who_wide   = 16'(req_i.owner_id);
  end

  // Command sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    own_d   = own_q;
    fit_d   = fit_q;
    exact_d = exact_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    latch   = 1'b0;
    unique case (state_q) inside
      S_IDLE: begin
        if (start) begin
          latch   = 1'b1;
          own_d   = 1'b0;
          fit_d   = 1'b0;
          exact_d = 1'b0;
          if ((req_i.kind == ffba_pkg::KIND_ALLOC) && (req_i.request_size == 11'd0)) begin
            done_d = 1'b1;
            rsp_d  = '{ok: 1'b0, status: ffba_pkg::ST_ZERO};
          end else begin
            state_d = S_SYNC;
          end
        end
      end
      S_SYNC, S_LAP1: begin
        if ((state_q == S_LAP1) || head_first) begin
          own_d   = own_n;
          fit_d   = fit_n;
          exact_d = exact_n;
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = S_LAP1;
          if (state_q == S_SYNC) begin
            cnt_d = IDX_W'(1);
          end else if (lap_last) begin
            cnt_d   = '0;
            state_d = S_LAP2;
            if (kind_q == ffba_pkg::KIND_FREE) begin
              if (!own_n) begin
                state_d = S_IDLE;
                done_d  = 1'b1;
                rsp_d   = '{ok: 1'b0, status: ffba_pkg::ST_NOTFOUND};
              end
            end else if (own_n) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              rsp_d   = '{ok: 1'b0, status: ffba_pkg::ST_BUSY};
            end else if (!fit_n) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              rsp_d   = '{ok: 1'b0, status: ffba_pkg::ST_NOFIT};
            end else if (!exact_n && full) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              rsp_d   = '{ok: 1'b0, status: ffba_pkg::ST_FULL};
            end
          end
        end
      end
      S_LAP2: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (lap_last) begin
          cnt_d   = '0;
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          rsp_d   = '{ok: 1'b1, status: ffba_pkg::ST_OK};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Number of valid entries in the ring.
  always_comb begin
    count_d = count_q + CNT_W'(stat.split) - CNT_W'(stat.merge);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      count_q <= CNT_W'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q   <= own_d;
    fit_q   <= fit_d;
    exact_q <= exact_d;
    rsp_q   <= rsp_d;
    if (latch) begin
      kind_q <= req_i.kind;
      who_q  <= who_wide[OWNER_BITS-1:0];
      size_q <= req_i.request_size;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- design/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell: one slot of the segment ring
// Holds one table entry and takes the entry of its neighbour every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell #(
  parameter int LEN_W      = 11,
  parameter int OWN_W      = 8,
  parameter int HEAP_WORDS = 1024,
  parameter bit HEAD       = 1'b0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             v_i,
  input  wire logic             f_i,
  input  wire logic             fr_i,
  input  wire logic [OWN_W-1:0] own_i,
  input  wire logic [LEN_W-1:0] len_i,
  output logic                  v_o,
  output logic                  f_o,
  output logic                  fr_o,
  output logic [OWN_W-1:0]      own_o,
  output logic [LEN_W-1:0]      len_o
);

  logic             v_q, f_q, fr_q;
  logic [OWN_W-1:0] own_q;
  logic [LEN_W-1:0] len_q;

  // Control bits and length; the head slot starts as the whole free heap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= HEAD;
      f_q   <= HEAD;
      fr_q  <= HEAD;
      len_q <= HEAD ? LEN_W'(HEAP_WORDS) : '0;
    end else begin
      v_q   <= v_i;
      f_q   <= f_i;
      fr_q  <= fr_i;
      len_q <= len_i;
    end
  end

  // The owner is only read for owned entries, which were always written.
  always_ff @(posedge clk_i) begin
    own_q <= own_i;
  end

  assign v_o   = v_q;
  assign f_o   = f_q;
  assign fr_o  = fr_q;
  assign own_o = own_q;
  assign len_o = len_q;

endmodule

`default_nettype wire

// ----- design/ffba_tail.sv -----
// ----------------------------------------------------------------------------
// ffba_tail: processing stage that closes the segment ring
// Looks at the head entry, marks, splits or merges it, and feeds the result
// into the last slot. A pending register absorbs the extra entry of a split
// and holds the run being merged during a release.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_tail #(
  parameter int LEN_W = 11,
  parameter int OWN_W = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ffba_pkg::tail_ctrl_t ctrl_i,
  input  wire logic [OWN_W-1:0]     who_i,
  input  wire logic [10:0]          size_i,
  input  wire logic                 in_v_i,
  input  wire logic                 in_f_i,
  input  wire logic                 in_fr_i,
  input  wire logic [OWN_W-1:0]     in_own_i,
  input  wire logic [LEN_W-1:0]     in_len_i,
  output logic                      out_v_o,
  output logic                      out_f_o,
  output logic                      out_fr_o,
  output logic [OWN_W-1:0]          out_own_o,
  output logic [LEN_W-1:0]          out_len_o,
  output ffba_pkg::tail_stat_t      stat_o
);

  localparam int CMP_W = (LEN_W > 11) ? LEN_W : 11;

  logic             pv_q, pv_d, pf_q, pf_d, pfr_q, pfr_d;
  logic [OWN_W-1:0] pown_q, pown_d;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic             taken_q, taken_d;

  logic [CMP_W-1:0] len_c, size_c;
  logic             match, fit, exact, fr_e;

  // Compare the head entry against the request.
  always_comb begin
    len_c  = CMP_W'(in_len_i);
    size_c = CMP_W'(size_i);
    match  = in_v_i && !in_fr_i && (in_own_i == who_i);
    fit    = in_v_i && in_fr_i && (len_c >= size_c);
    exact  = (len_c == size_c);
    fr_e   = in_fr_i | match;
  end

  // Entry rewrite and pending register update.
  always_comb begin
    out_v_o   = in_v_i;
    out_f_o   = in_f_i;
    out_fr_o  = in_fr_i;
    out_own_o = in_own_i;
    out_len_o = in_len_i;
    pv_d      = pv_q;
    pf_d      = pf_q;
    pfr_d     = pfr_q;
    pown_d    = pown_q;
    plen_d    = plen_q;
    taken_d   = taken_q;
    stat_o    = '0;
    stat_o.match  = match;
    stat_o.fit    = fit;
    stat_o.exact  = exact;
    stat_o.pend_v = pv_q;

    case (ctrl_i.mode)
      ffba_pkg::TM_ALLOC: begin
        if (!ctrl_i.flush && !taken_q && fit) begin
          // First fitting free segment: take it whole or split it.
          taken_d   = 1'b1;
          out_fr_o  = 1'b0;
          out_own_o = who_i;
          if (!exact) begin
            out_len_o    = LEN_W'(size_c);
            pv_d         = 1'b1;
            pf_d         = 1'b0;
            pfr_d        = 1'b1;
            pown_d       = who_i;
            plen_d       = LEN_W'(len_c - size_c);
            stat_o.split = 1'b1;
          end
        end else if (pv_q) begin
          // Everything behind the split moves one slot until a gap is met.
          out_v_o   = 1'b1;
          out_f_o   = pf_q;
          out_fr_o  = pfr_q;
          out_own_o = pown_q;
          out_len_o = plen_q;
          pv_d      = in_v_i;
          pf_d      = in_f_i;
          pfr_d     = in_fr_i;
          pown_d    = in_own_i;
          plen_d    = in_len_i;
        end
      end
      ffba_pkg::TM_FREE: begin
        if (!ctrl_i.flush) begin
          // Hold the last entry; fold a free entry into a held free one.
          if (in_v_i) begin
            if (pv_q && pfr_q && fr_e) begin
              out_v_o      = 1'b0;
              plen_d       = plen_q + in_len_i;
              stat_o.merge = 1'b1;
            end else begin
              out_v_o   = pv_q;
              out_f_o   = pf_q;
              out_fr_o  = pfr_q;
              out_own_o = pown_q;
              out_len_o = plen_q;
              pv_d      = 1'b1;
              pf_d      = in_f_i;
              pfr_d     = fr_e;
              pown_d    = in_own_i;
              plen_d    = in_len_i;
            end
          end
        end else if (pv_q) begin
          out_v_o   = 1'b1;
          out_f_o   = pf_q;
          out_fr_o  = pfr_q;
          out_own_o = pown_q;
          out_len_o = plen_q;
          pv_d      = in_v_i;
          pf_d      = in_f_i;
          pfr_d     = in_fr_i;
          pown_d    = in_own_i;
          plen_d    = in_len_i;
        end
      end
      default: begin
        taken_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      pv_q    <= pv_d;
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pf_q   <= pf_d;
    pfr_q  <= pfr_d;
    pown_q <= pown_d;
    plen_q <= plen_d;
  end

endmodule

`default_nettype wire

// ----- design/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker: port-level checks of the allocator
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire ffba_pkg::req_t req_i,
  input wire logic           done_o,
  input wire ffba_pkg::rsp_t rsp_o
);

  // The ok flag agrees with the status code.
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.ok == (rsp_o.status == ffba_pkg::ST_OK)))
    else $error("ok flag disagrees with status");

  // A zero-size allocate is answered in the next cycle with its own code.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.kind == ffba_pkg::KIND_ALLOC) && (req_i.request_size == 11'd0))
    |=> (done_o && (rsp_o.status == ffba_pkg::ST_ZERO) && !busy))
    else $error("zero-size allocate not answered at once");

  // Any other accepted command keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !((req_i.kind == ffba_pkg::KIND_ALLOC) && (req_i.request_size == 11'd0)))
    |=> (busy && !done_o))
    else $error("accepted command did not occupy the block");

  // A result only follows a busy cycle or an accepted command.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result transfer without a command");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the first-fit block allocator core
// A directed table of commands and a run that fills the segment table
// are followed by random allocate and free traffic. A model of the
// segment table inside the bench predicts the status of every command,
// and each result is checked against that prediction.
`timescale 1ns / 100ps

module tb_top;

  localparam int ENTRIES   = 64;
  localparam int HEAP      = 1024;
  localparam int N_RANDOM  = 1710;
  localparam int CYCLE_CAP = 3000000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  ffba_pkg::req_t req_i;
  logic           done_o;
  ffba_pkg::rsp_t rsp_o;

  first_fit_block_allocator_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // Segment table as the bench sees it.
  int unsigned  tbl_start[ENTRIES+1];
  int unsigned  tbl_len[ENTRIES+1];
  logic [7:0]   tbl_owner[ENTRIES+1];
  bit           tbl_free[ENTRIES+1];
  int unsigned  tbl_count;

  ffba_pkg::rsp_t expected_rsp[$];
  int             error_count;
  int             cycle_count = 0;
  bit             gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int owner_index(input logic [7:0] who);
    for (int i = 0; i < tbl_count; i++)
      if (!tbl_free[i] && tbl_owner[i] == who) return i;
    return -1;
  endfunction

  function automatic void table_reset();
    tbl_count = 1;
    tbl_start[0] = 0;
    tbl_len[0] = HEAP;
    tbl_free[0] = 1'b1;
    tbl_owner[0] = '0;
  endfunction

  function automatic void shift_down(input int from);
    for (int j = from; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_len[j]   = tbl_len[j+1];
      tbl_owner[j] = tbl_owner[j+1];
      tbl_free[j]  = tbl_free[j+1];
    end
    tbl_count--;
  endfunction

  // Applies one command to the bench table and returns its status.
  function automatic logic [2:0] apply_command(input ffba_pkg::req_t r);
    int idx;
    int i;
    if (r.kind == ffba_pkg::KIND_ALLOC) begin
      if (r.request_size == 0) return ffba_pkg::ST_ZERO;
      if (owner_index(r.owner_id) >= 0) return ffba_pkg::ST_BUSY;
      for (int s = 0; s < tbl_count; s++) begin
        if (tbl_free[s] && tbl_len[s] >= r.request_size) begin
          if (tbl_len[s] == r.request_size) begin
            tbl_free[s] = 1'b0;
            tbl_owner[s] = r.owner_id;
            return ffba_pkg::ST_OK;
          end
          if (tbl_count >= ENTRIES) return ffba_pkg::ST_FULL;
          for (int j = tbl_count; j > s; j--) begin
            tbl_start[j] = tbl_start[j-1];
            tbl_len[j]   = tbl_len[j-1];
            tbl_owner[j] = tbl_owner[j-1];
            tbl_free[j]  = tbl_free[j-1];
          end
          tbl_start[s+1] = tbl_start[s] + r.request_size;
          tbl_len[s+1]   = tbl_len[s] - r.request_size;
          tbl_len[s]     = r.request_size;
          tbl_owner[s]   = r.owner_id;
          tbl_free[s]    = 1'b0;
          tbl_count++;
          return ffba_pkg::ST_OK;
        end
      end
      return ffba_pkg::ST_NOFIT;
    end
    idx = owner_index(r.owner_id);
    if (idx < 0) return ffba_pkg::ST_NOTFOUND;
    tbl_free[idx] = 1'b1;
    tbl_owner[idx] = '0;
    // Merge every run of adjacent free segments.
    i = 0;
    while (tbl_count > 1 && i + 1 < tbl_count) begin
      if (tbl_free[i] && tbl_free[i+1]) begin
        tbl_len[i] += tbl_len[i+1];
        shift_down(i + 1);
      end else begin
        i++;
      end
    end
    return ffba_pkg::ST_OK;
  endfunction

  // Drives one command and queues its predicted result; a typed-in status
  // of 7 means none was given and the prediction stands alone. The command
  // stays on the inputs after its transfer until the next one replaces it
  // or an idle stretch clears it.
  task automatic send_command(input ffba_pkg::req_t r, input logic [2:0] typed_status);
    ffba_pkg::rsp_t prd;
    if (gaps_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      req_i <= '0;
      do @(negedge clk_i); while (gaps_on && $urandom_range(99) < 6);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    prd.status = apply_command(r);
    prd.ok = (prd.status == ffba_pkg::ST_OK);
    if (typed_status != 3'd7 && typed_status != prd.status)
      report_mismatch($sformatf("bench table gives %0d, typed %0d",
                                prd.status, typed_status));
    expected_rsp.push_back(prd);
    @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    ffba_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_o.ok !== want.ok)
          report_mismatch($sformatf("ok %b, expected %b", rsp_o.ok, want.ok));
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_o.status, want.status));
      end
    end
  end

  function automatic ffba_pkg::req_t make_req(input logic k, input int who, input int sz);
    ffba_pkg::req_t r;
    r.kind = k;
    r.owner_id = who[7:0];
    r.request_size = sz[10:0];
    return r;
  endfunction

  typedef struct {
    logic       k;
    int         who;
    int         sz;
    logic [2:0] st;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{ffba_pkg::KIND_FREE,  0,   0,    ffba_pkg::ST_NOTFOUND},
    '{ffba_pkg::KIND_ALLOC, 1,   0,    ffba_pkg::ST_ZERO},
    '{ffba_pkg::KIND_ALLOC, 2,   1025, ffba_pkg::ST_NOFIT},
    '{ffba_pkg::KIND_ALLOC, 3,   2047, ffba_pkg::ST_NOFIT},
    '{ffba_pkg::KIND_ALLOC, 255, 1,    ffba_pkg::ST_OK},
    '{ffba_pkg::KIND_ALLOC, 255, 5,    ffba_pkg::ST_BUSY},
    '{ffba_pkg::KIND_ALLOC, 0,   100,  3'd7},
    '{ffba_pkg::KIND_ALLOC, 170, 200,  3'd7},
    '{ffba_pkg::KIND_FREE,  0,   2047, 3'd7},
    '{ffba_pkg::KIND_ALLOC, 85,  100,  3'd7},
    '{ffba_pkg::KIND_FREE,  255, 0,    3'd7},
    '{ffba_pkg::KIND_FREE,  85,  0,    3'd7},
    '{ffba_pkg::KIND_FREE,  170, 0,    3'd7},
    '{ffba_pkg::KIND_FREE,  170, 0,    ffba_pkg::ST_NOTFOUND},
    '{ffba_pkg::KIND_ALLOC, 7,   1024, ffba_pkg::ST_OK},
    '{ffba_pkg::KIND_ALLOC, 8,   1,    ffba_pkg::ST_NOFIT},
    '{ffba_pkg::KIND_FREE,  7,   0,    ffba_pkg::ST_OK}
  };

  initial begin
    ffba_pkg::req_t r;
    int             roll;
    error_count = 0;
    gaps_on = 1'b1;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    table_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    foreach (directed_rows[n])
      send_command(make_req(directed_rows[n].k, directed_rows[n].who,
                            directed_rows[n].sz), directed_rows[n].st);

    // Fill the table with small segments and alternate frees to reach the
    // table full case.
    for (int n = 0; n < 70; n++)
      send_command(make_req(ffba_pkg::KIND_ALLOC, n, 1 + (n % 3)), 3'd7);
    for (int n = 0; n < 64; n += 2)
      send_command(make_req(ffba_pkg::KIND_FREE, n, 0), 3'd7);
    send_command(make_req(ffba_pkg::KIND_ALLOC, 200, 1), 3'd7);
    for (int n = 0; n < 70; n++)
      send_command(make_req(ffba_pkg::KIND_FREE, n, 0), 3'd7);
    send_command(make_req(ffba_pkg::KIND_FREE, 200, 0), 3'd7);

    // Random part: mostly small sizes and a small owner pool so that frees
    // hit, with occasional wide owners and large sizes.
    for (int n = 0; n < N_RANDOM; n++) begin
      gaps_on = !(n >= 600 && n < 900);
      roll = $urandom_range(99);
      r.kind = ($urandom_range(99) < 45) ? ffba_pkg::KIND_FREE : ffba_pkg::KIND_ALLOC;
      r.owner_id = (roll < 80) ? 8'($urandom_range(47)) : 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 70)      r.request_size = 11'($urandom_range(40, 1));
      else if (roll < 85) r.request_size = 11'($urandom_range(300, 1));
      else if (roll < 90) r.request_size = 11'd0;
      else                r.request_size = 11'($urandom);
      send_command(r, 3'd7);
    end

    // Take the last command off the inputs.
    start <= 1'b0;
    req_i <= '0;

    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
